FILE: rtl/lrbm_pkg.sv
// Shared types, constants and rounding helpers for the look-rotation basis unit.
// No dependencies.
package lrbm_pkg;

    // Root bits of the length and quotient bits of each unit component.
    localparam int SQ_N = 30;
    localparam int DV_N = 16;

    // Fixed near-vertical up vector, normalized, in Q2.30.
    localparam logic signed [31:0] UPC_X = 32'sd1073741;
    localparam logic signed [31:0] UPC_Y = 32'sd1073741287;
    localparam logic [15:0] UNIT_ONE = 16'd16384;

    // Scales, signs, magnitudes and the zero flag that ride along with the word through the pipeline.
    typedef struct packed {
        logic signed [15:0] sc_x;
        logic signed [15:0] sc_y;
        logic signed [15:0] sc_z;
        logic [2:0] neg;
        logic [2:0][15:0] mag;
        logic zero;
    } t_carry;

    // Round to nearest with ties away from zero, dropping 14 bits.
    function automatic logic signed [63:0] rnd14(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (!v[63]) begin
            r = (v + 64'sd8192) >>> 14;
        end else begin
            r = -((-v + 64'sd8192) >>> 14);
        end
        return r;
    endfunction

    // Same rounding, dropping 16 bits.
    function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (!v[63]) begin
            r = (v + 64'sd32768) >>> 16;
        end else begin
            r = -((-v + 64'sd32768) >>> 16);
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/look_rotation_basis_matrix_unit.sv
// Look-rotation basis matrix: normalize, two cross products, row scaling.
// Uses lrbm_pkg for constants, the carried-field type and rounding helpers.
// Accepts one word per cycle while the output is not held.
// The length square root (one root bit per stage) and the three unit-component
// dividers (one quotient bit per stage) set the depth; the pipeline has no feedback.
// A held output stalls all stages together. Reset clears only the valid bits.
module look_rotation_basis_matrix_unit
    import lrbm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [15:0]  i_dir_x,
    input  logic signed [15:0]  i_dir_y,
    input  logic signed [15:0]  i_dir_z,
    input  logic signed [15:0]  i_scale_x,
    input  logic signed [15:0]  i_scale_y,
    input  logic signed [15:0]  i_scale_z,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [31:0]  o_m_right_x,
    output logic signed [31:0]  o_m_right_y,
    output logic signed [31:0]  o_m_right_z,
    output logic signed [31:0]  o_m_up_x,
    output logic signed [31:0]  o_m_up_y,
    output logic signed [31:0]  o_m_up_z,
    output logic signed [31:0]  o_m_front_x,
    output logic signed [31:0]  o_m_front_y,
    output logic signed [31:0]  o_m_front_z,
    output logic signed [15:0]  o_unit_front_x,
    output logic signed [15:0]  o_unit_front_y,
    output logic                o_zero_direction
);

    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // ---------------- squares ----------------
    t_carry n_in_c;
    logic   r_p_v;
    t_carry r_p_c;
    logic [2:0][31:0] r_p_sq;

    always_comb begin
        n_in_c.sc_x   = i_scale_x;
        n_in_c.sc_y   = i_scale_y;
        n_in_c.sc_z   = i_scale_z;
        n_in_c.neg    = {i_dir_z[15], i_dir_y[15], i_dir_x[15]};
        n_in_c.mag[0] = i_dir_x[15] ? 16'(-i_dir_x) : i_dir_x;
        n_in_c.mag[1] = i_dir_y[15] ? 16'(-i_dir_y) : i_dir_y;
        n_in_c.mag[2] = i_dir_z[15] ? 16'(-i_dir_z) : i_dir_z;
        n_in_c.zero   = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_c <= n_in_c;
            for (int i = 0; i < 3; i++) begin
                r_p_sq[i] <= n_in_c.mag[i] * n_in_c.mag[i];
            end
        end
    end

    // ---------------- square root of S * 2^28 ----------------
    logic   r_sq_v    [0:SQ_N];
    t_carry r_sq_c    [0:SQ_N];
    logic [31:0] r_sq_s    [0:SQ_N];
    logic [33:0] r_sq_rem  [0:SQ_N];
    logic [29:0] r_sq_root [0:SQ_N];

    logic [31:0] n_sum;
    t_carry      n_sum_c;
    always_comb begin
        n_sum        = r_p_sq[0] + r_p_sq[1] + r_p_sq[2];
        n_sum_c      = r_p_c;
        n_sum_c.zero = (n_sum == 32'd0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_c[0]    <= n_sum_c;
            r_sq_s[0]    <= n_sum;
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
        end
    end

    for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
        // Pair (29 - k) of the radicand; its low 28 bits are zero.
        localparam int P = SQ_N - 1 - k;
        logic [1:0]  pair;
        logic [33:0] rem2;
        logic [33:0] trial;
        if (P >= 14) begin : g_hi
            assign pair = r_sq_s[k][2*P-27 -: 2];
        end else begin : g_lo
            assign pair = 2'b00;
        end
        assign rem2  = {r_sq_rem[k][31:0], pair};
        assign trial = {2'b00, r_sq_root[k], 2'b01};
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_c[k+1] <= r_sq_c[k];
                r_sq_s[k+1] <= r_sq_s[k];
                if (rem2 >= trial) begin
                    r_sq_rem[k+1]  <= rem2 - trial;
                    r_sq_root[k+1] <= {r_sq_root[k][28:0], 1'b1};
                end else begin
                    r_sq_rem[k+1]  <= rem2;
                    r_sq_root[k+1] <= {r_sq_root[k][28:0], 1'b0};
                end
            end
        end
    end

    // ---------------- unit components: (mag*2^28 + n/2) / n ----------------
    logic   r_dv_v [0:DV_N];
    t_carry r_dv_c [0:DV_N];
    logic [29:0]       r_dv_n   [0:DV_N];
    logic [2:0][29:0]  r_dv_rem [0:DV_N];
    logic [2:0][15:0]  r_dv_lo  [0:DV_N];
    logic [2:0][15:0]  r_dv_q   [0:DV_N];

    logic [2:0][44:0] n_num;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_num[i] = {1'b0, r_sq_c[SQ_N].mag[i], 28'd0}
                     + {16'd0, r_sq_root[SQ_N][29:1]};
        end
    end

    // The quotient stays below 2^16, so the top bits already sit below n.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_c[0] <= r_sq_c[SQ_N];
            r_dv_n[0] <= r_sq_root[SQ_N];
            for (int i = 0; i < 3; i++) begin
                r_dv_rem[0][i] <= {1'b0, n_num[i][44:16]};
                r_dv_lo[0][i]  <= n_num[i][15:0];
                r_dv_q[0][i]   <= '0;
            end
        end
    end

    for (genvar k = 0; k < DV_N; k++) begin : g_div
        localparam int B = DV_N - 1 - k;
        logic [2:0][30:0] rem2;
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                rem2[i] = {r_dv_rem[k][i], r_dv_lo[k][i][B]};
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_c[k+1]  <= r_dv_c[k];
                r_dv_n[k+1]  <= r_dv_n[k];
                r_dv_lo[k+1] <= r_dv_lo[k];
                for (int i = 0; i < 3; i++) begin
                    if (rem2[i] >= {1'b0, r_dv_n[k]}) begin
                        r_dv_rem[k+1][i] <= 30'(rem2[i] - {1'b0, r_dv_n[k]});
                        r_dv_q[k+1][i]   <= {r_dv_q[k][i][14:0], 1'b1};
                    end else begin
                        r_dv_rem[k+1][i] <= rem2[i][29:0];
                        r_dv_q[k+1][i]   <= {r_dv_q[k][i][14:0], 1'b0};
                    end
                end
            end
        end
    end

    // ---------------- front, then right = u x f, then up = f x r ----------------
    logic r_f_v, r_m1_v, r_r1_v, r_m2_v, r_r2_v, r_m3_v;
    t_carry r_f_c, r_m1_c, r_r1_c, r_m2_c, r_r2_c, r_m3_c;
    logic signed [15:0] r_f [3];
    logic signed [15:0] r_m1_f [3];
    logic signed [15:0] r_r1_f [3];
    logic signed [15:0] r_m2_f [3];
    logic signed [15:0] r_r2_f [3];
    logic signed [15:0] r_m3_f [3];
    logic signed [47:0] r_m1_p [4];
    logic signed [32:0] r_r1_rg [3];
    logic signed [32:0] r_m2_rg [3];
    logic signed [48:0] r_m2_p [6];
    logic signed [32:0] r_r2_rg [3];
    logic signed [33:0] r_r2_uv [3];
    logic signed [48:0] r_m3_r [3];
    logic signed [49:0] r_m3_u [3];
    logic signed [31:0] r_m3_fs [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            // Clamp a rounded-up component back to exactly one.
            r_f_c <= r_dv_c[DV_N];
            for (int i = 0; i < 3; i++) begin
                logic [15:0] q;
                q = (r_dv_q[DV_N][i] > UNIT_ONE) ? UNIT_ONE : r_dv_q[DV_N][i];
                r_f[i] <= r_dv_c[DV_N].neg[i] ? 16'(-q) : q;
            end

            r_m1_c    <= r_f_c;
            r_m1_f    <= r_f;
            r_m1_p[0] <= UPC_Y * r_f[2];
            r_m1_p[1] <= -(UPC_X * r_f[2]);
            r_m1_p[2] <= UPC_X * r_f[1];
            r_m1_p[3] <= UPC_Y * r_f[0];

            r_r1_c     <= r_m1_c;
            r_r1_f     <= r_m1_f;
            r_r1_rg[0] <= 33'(rnd14(64'(r_m1_p[0])));
            r_r1_rg[1] <= 33'(rnd14(64'(r_m1_p[1])));
            r_r1_rg[2] <= 33'(rnd14(64'(r_m1_p[2]) - 64'(r_m1_p[3])));

            r_m2_c    <= r_r1_c;
            r_m2_f    <= r_r1_f;
            r_m2_rg   <= r_r1_rg;
            r_m2_p[0] <= r_r1_f[1] * r_r1_rg[2];
            r_m2_p[1] <= r_r1_f[2] * r_r1_rg[1];
            r_m2_p[2] <= r_r1_f[2] * r_r1_rg[0];
            r_m2_p[3] <= r_r1_f[0] * r_r1_rg[2];
            r_m2_p[4] <= r_r1_f[0] * r_r1_rg[1];
            r_m2_p[5] <= r_r1_f[1] * r_r1_rg[0];

            r_r2_c     <= r_m2_c;
            r_r2_f     <= r_m2_f;
            r_r2_rg    <= r_m2_rg;
            r_r2_uv[0] <= 34'(rnd14(64'(r_m2_p[0]) - 64'(r_m2_p[1])));
            r_r2_uv[1] <= 34'(rnd14(64'(r_m2_p[2]) - 64'(r_m2_p[3])));
            r_r2_uv[2] <= 34'(rnd14(64'(r_m2_p[4]) - 64'(r_m2_p[5])));

            r_m3_c <= r_r2_c;
            r_m3_f <= r_r2_f;
            for (int i = 0; i < 3; i++) begin
                r_m3_r[i]  <= r_r2_rg[i] * r_r2_c.sc_x;
                r_m3_u[i]  <= r_r2_uv[i] * r_r2_c.sc_y;
                r_m3_fs[i] <= r_r2_f[i] * r_r2_c.sc_z;
            end

            // A zero direction sets the flag and forces every other field to zero.
            o_zero_direction <= r_m3_c.zero;
            o_unit_front_x   <= r_m3_c.zero ? '0 : r_m3_f[0];
            o_unit_front_y   <= r_m3_c.zero ? '0 : r_m3_f[1];
            o_m_right_x <= r_m3_c.zero ? '0 : sat32(rnd16(64'(r_m3_r[0])));
            o_m_right_y <= r_m3_c.zero ? '0 : sat32(rnd16(64'(r_m3_r[1])));
            o_m_right_z <= r_m3_c.zero ? '0 : sat32(rnd16(64'(r_m3_r[2])));
            o_m_up_x    <= r_m3_c.zero ? '0 : sat32(rnd16(64'(r_m3_u[0])));
            o_m_up_y    <= r_m3_c.zero ? '0 : sat32(rnd16(64'(r_m3_u[1])));
            o_m_up_z    <= r_m3_c.zero ? '0 : sat32(rnd16(64'(r_m3_u[2])));
            o_m_front_x <= r_m3_c.zero ? '0 : r_m3_fs[0];
            o_m_front_y <= r_m3_c.zero ? '0 : r_m3_fs[1];
            o_m_front_z <= r_m3_c.zero ? '0 : r_m3_fs[2];
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v   <= 1'b0;
            r_f_v   <= 1'b0;
            r_m1_v  <= 1'b0;
            r_r1_v  <= 1'b0;
            r_m2_v  <= 1'b0;
            r_r2_v  <= 1'b0;
            r_m3_v  <= 1'b0;
            o_valid <= 1'b0;
            for (int k = 0; k <= SQ_N; k++) begin
                r_sq_v[k] <= 1'b0;
            end
            for (int k = 0; k <= DV_N; k++) begin
                r_dv_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_p_v     <= i_valid;
            r_sq_v[0] <= r_p_v;
            for (int k = 0; k < SQ_N; k++) begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
            r_dv_v[0] <= r_sq_v[SQ_N];
            for (int k = 0; k < DV_N; k++) begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
            r_f_v   <= r_dv_v[DV_N];
            r_m1_v  <= r_f_v;
            r_r1_v  <= r_m1_v;
            r_m2_v  <= r_r1_v;
            r_r2_v  <= r_m2_v;
            r_m3_v  <= r_r2_v;
            o_valid <= r_m3_v;
        end
    end

    // ---------------- checks ----------------
    a_ready_follows_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready does not follow the output stall");

    a_zero_outputs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_direction) |-> (o_m_front_z == 32'sd0 && o_m_right_x == 32'sd0
            && o_m_up_y == 32'sd0 && o_unit_front_x == 16'sd0))
        else $error("zero direction word has nonzero fields");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_unit_front_x <= 16'sd16384 && o_unit_front_x >= -16'sd16384
            && o_unit_front_y <= 16'sd16384 && o_unit_front_y >= -16'sd16384))
        else $error("unit front component beyond one");

endmodule

FILE: dv/tb_look_rotation_basis_matrix_unit.sv
// Testbench for the look-rotation basis matrix unit: directed table plus random words,
// each result checked against a built-in predictor. Depends on rtl/lrbm_pkg.sv and the unit.
module tb_look_rotation_basis_matrix_unit
    import lrbm_pkg::*;
();

    typedef struct {
        logic signed [15:0] dx, dy, dz, sx, sy, sz;
    } t_dir_word;

    typedef struct {
        logic signed [31:0] m [9];
        logic signed [15:0] ufx, ufy;
        logic               zero;
    } t_basis;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_ready = 1'b0;
    logic signed [15:0] i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    logic signed [15:0] i_scale_x = '0, i_scale_y = '0, i_scale_z = '0;
    logic               o_ready, o_valid, o_zero_direction;
    logic signed [31:0] o_m_right_x, o_m_right_y, o_m_right_z;
    logic signed [31:0] o_m_up_x, o_m_up_y, o_m_up_z;
    logic signed [31:0] o_m_front_x, o_m_front_y, o_m_front_z;
    logic signed [15:0] o_unit_front_x, o_unit_front_y;

    t_basis expected_basis_q[$];
    int     error_count = 0;
    bit     send_done = 1'b0;
    bit     hold_off = 1'b0;

    look_rotation_basis_matrix_unit dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #50000000;
        $display("look_rotation_basis_matrix_unit verification failed");
        $finish;
    end

    function automatic longint round_drop(longint v, int k);
        longint half;
        half = longint'(1) << (k - 1);
        if (v >= 0) return (v + half) >>> k;
        return -((-v + half) >>> k);
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint isqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unit_part(longint d, longint n);
        longint q, mag;
        mag = d < 0 ? -d : d;
        q = ((mag << 28) + n / 2) / n;
        if (q > 16384) q = 16384;
        return d < 0 ? -q : q;
    endfunction

    function automatic t_basis predict_basis(t_dir_word w);
        t_basis b;
        longint d[3], f[3], r[3], v[3], sc[3], ssq, n;
        d[0] = w.dx; d[1] = w.dy; d[2] = w.dz;
        sc[0] = w.sx; sc[1] = w.sy; sc[2] = w.sz;
        ssq = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
        foreach (b.m[i]) b.m[i] = '0;
        b.ufx = '0; b.ufy = '0; b.zero = 1'b1;
        if (ssq == 0) return b;
        n = isqrt(ssq << 28);
        for (int i = 0; i < 3; i++) f[i] = unit_part(d[i], n);
        r[0] = round_drop(longint'(UPC_Y) * f[2], 14);
        r[1] = round_drop(-longint'(UPC_X) * f[2], 14);
        r[2] = round_drop(longint'(UPC_X) * f[1] - longint'(UPC_Y) * f[0], 14);
        v[0] = round_drop(f[1] * r[2] - f[2] * r[1], 14);
        v[1] = round_drop(f[2] * r[0] - f[0] * r[2], 14);
        v[2] = round_drop(f[0] * r[1] - f[1] * r[0], 14);
        for (int i = 0; i < 3; i++) begin
            b.m[i] = clip32(round_drop(r[i] * sc[0], 16));
            b.m[3 + i] = clip32(round_drop(v[i] * sc[1], 16));
            b.m[6 + i] = clip32(f[i] * sc[2]);
        end
        b.ufx = f[0][15:0];
        b.ufy = f[1][15:0];
        b.zero = 1'b0;
        return b;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Valid drops only when the next word is held back, so back-to-back words keep it high.
    task automatic send_word(t_dir_word w);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_dir_x <= w.dx; i_dir_y <= w.dy; i_dir_z <= w.dz;
        i_scale_x <= w.sx; i_scale_y <= w.sy; i_scale_z <= w.sz;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        expected_basis_q.push_back(predict_basis(w));
        @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 6)) - 16'sd3;
            default: return 16'($urandom);
        endcase
    endfunction

    // Directed rows: extremes, zero direction, near-vertical and axis-aligned directions.
    t_dir_word directed_rows[] = '{
        '{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd256, 16'sd256},
        '{16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh8000, 16'sd1},
        '{16'sd0, 16'sd0, 16'sd1, 16'sd256, 16'sd256, 16'sd256},
        '{16'sd0, 16'sd0, 16'sh8000, 16'sd256, 16'sd256, 16'sd256},
        '{16'sd1, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
        '{16'sh8000, 16'sd0, 16'sd0, 16'sh8000, 16'sh8000, 16'sh8000},
        '{16'sd0, 16'sd1, 16'sd0, 16'sd256, 16'sd256, 16'sd256},
        '{16'sd0, 16'sh7FFF, 16'sd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
        '{16'sd0, 16'sh8000, 16'sd0, 16'sh8000, 16'sh8000, 16'sh8000},
        '{16'sd1, 16'sd1000, 16'sd0, 16'sd256, 16'sd256, 16'sd256},
        '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF},
        '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000},
        '{16'sd1, 16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd3, 16'sd4, 16'sd0, 16'sd256, 16'sd256, 16'sd256},
        '{16'sd2, 16'sd2, 16'sd1, 16'sd256, 16'sh8000, 16'sd1},
        '{16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF}
    };

    initial begin
        t_dir_word w;
        t_basis p;
        bit bad;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_rows[i]) begin
            send_word(directed_rows[i]);
            // The zero direction reads straight off: all zero, flag set.
            if (i < 2) begin
                p = predict_basis(directed_rows[i]);
                bad = !p.zero || p.ufx != 16'sd0 || p.ufy != 16'sd0;
                foreach (p.m[j]) if (p.m[j] != 32'sd0) bad = 1'b1;
                if (bad) report_mismatch("zero-direction predictor", 0, 1);
            end
        end
        for (int k = 0; k < 400; k++) begin
            w.dx = rand_field(); w.dy = rand_field(); w.dz = rand_field();
            w.sx = rand_field(); w.sy = rand_field(); w.sz = rand_field();
            if (k == 150) hold_off = 1'b1;
            send_word(w);
        end
        i_valid <= 1'b0;
        send_done = 1'b1;
    end

    // Receiver: random stalls, plus one long hold so the pipeline backs up.
    initial begin
        int stall;
        bit held;
        held = 1'b0;
        i_ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off && !held) begin
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (200) @(negedge i_clk);
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_basis want;
        logic signed [31:0] got [9];
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_m_right_x, o_m_right_y, o_m_right_z, o_m_up_x, o_m_up_y,
                    o_m_up_z, o_m_front_x, o_m_front_y, o_m_front_z};
            if (expected_basis_q.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                want = expected_basis_q.pop_front();
                foreach (got[i])
                    if (got[i] !== want.m[i]) report_mismatch($sformatf("m[%0d]", i),
                                                                got[i], want.m[i]);
                if (o_unit_front_x !== want.ufx)
                    report_mismatch("unit_front_x", o_unit_front_x, want.ufx);
                if (o_unit_front_y !== want.ufy)
                    report_mismatch("unit_front_y", o_unit_front_y, want.ufy);
                if (o_zero_direction !== want.zero)
                    report_mismatch("zero_direction", o_zero_direction, want.zero);
            end
        end
    end

    initial begin
        wait (send_done);
        wait (expected_basis_q.size() == 0);
        repeat (120) @(posedge i_clk);
        if (error_count == 0 && expected_basis_q.size() == 0) begin
            $display("look_rotation_basis_matrix_unit verification clean");
        end else begin
            $display("look_rotation_basis_matrix_unit verification failed");
        end
        $finish;
    end

endmodule
